[design/assert_macros.svh]
// Assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

[design/cth_pkg.sv]
package cth_pkg;
  localparam int unsigned CHANNELS_DEF    = 16;
  localparam int unsigned BINS_DEF        = 200;
  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int signed   RANGE_LO        = -200;
  localparam int unsigned RANGE_SPAN      = 750;
  localparam int unsigned AMP_W           = 16;
  localparam int unsigned OUT_CNT_W       = 32;

  localparam logic [1:0] REG_MAIN = 2'd0;
  localparam logic [1:0] REG_HIGH = 2'd1;
  localparam logic [1:0] REG_LOW  = 2'd2;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_READ   = 1'b1;
  localparam logic KIND_TRIG   = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam signed [AMP_W-1:0] THR_MAIN_RST = 16'sd150;
  localparam signed [AMP_W-1:0] THR_HIGH_RST = 16'sd200;
  localparam signed [AMP_W-1:0] THR_LOW_RST  = 16'sd100;

  // Input beat tdata fields, highest bit first.
  typedef struct packed {
    logic [7:0]             read_bin;
    logic                   read_bank;
    logic signed [AMP_W-1:0] trigger_sample;
    logic signed [AMP_W-1:0] sample_b;
    logic signed [AMP_W-1:0] sample_a;
    logic [3:0]             channel;
  } in_beat_t;
endpackage

[design/cth_binner.sv]
// Two-stage bin index: offset and range check, then scale by reciprocal.
module cth_binner #(
  parameter int unsigned BINS = cth_pkg::BINS_DEF,
  parameter int unsigned BW   = $clog2(BINS + 2)
) (
  input  logic                          clk_i,
  input  logic signed [cth_pkg::AMP_W-1:0] x_i,
  output logic [BW-1:0]                 bin_o
);
  import cth_pkg::*;
  localparam int unsigned RECIP_SH = 24;
  localparam longint unsigned RECIP =
    ((longint'(BINS) << RECIP_SH) + RANGE_SPAN - 1) / RANGE_SPAN;

  logic signed [AMP_W:0] off;
  logic [9:0]            off_q;
  logic                  under_q, over_q;
  logic [47:0]           prod;

  assign off = 17'(x_i) - 17'(RANGE_LO);

  // Stage one: offset and range flags.
  always_ff @(posedge clk_i) begin
    under_q <= off < 0;
    over_q  <= off >= 17'(RANGE_SPAN);
    off_q   <= off[9:0];
  end

  // Stage two: off*BINS/SPAN; rounded-up reciprocal is exact for off < 750.
  assign prod = 48'(off_q) * 48'(RECIP);
  always_comb begin
    if (under_q) bin_o = '0;
    else if (over_q) bin_o = BW'(BINS + 1);
    else bin_o = BW'(prod >> RECIP_SH) + BW'(1);
  end
endmodule

[design/coincidence_triggered_histogrammer_top.sv]
// Coincidence-triggered pulse-height histogrammer.
// Input stream s_axis: tuser = func, tlast = event_end; tdata carries the
// channel, three amplitudes, read_bank and read_bin. A sample beat stores
// one channel; a beat with tlast closes the event, forms triggers A and B,
// and increments one bin of each of the 16 histograms of each fired bank.
// A read beat (tuser=1) returns one bin count.
// Output stream m_axis: tuser = result_kind, tdata = trigger_a, trigger_b,
// bin_count. One output register holds a result until m_axis_tready.
// Flow: a plain sample beat leaves the block ready for the next beat; a read
// goes through memory read, then result. An event end walks up to 32
// read-modify-write steps, one per channel of each fired bank, through the
// single histogram memory, each step being bin, read, write.
// Reset: thresholds go to 150/200/100 and a clearing pass zeroes all
// 2*CHANNELS*(BINS+2) = 6464 memory words, during which s_axis_tready
// stays low. Config writes are taken at any time.
// A stalled receiver holds the result and blocks new input beats.
module coincidence_triggered_histogrammer_top #(
  parameter int unsigned CHANNELS    = cth_pkg::CHANNELS_DEF,
  parameter int unsigned BINS        = cth_pkg::BINS_DEF,
  parameter int unsigned COUNT_WIDTH = cth_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // channel[3:0], sample_a[19:4], sample_b[35:20], trigger_sample[51:36],
  // read_bank[52], read_bin[60:53], zero pad [63:61]
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // func
  input  logic        s_axis_tlast,   // event_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // trigger_a[0], trigger_b[1], bin_count[33:2], zero pad [39:34]
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tuser,   // result_kind
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import cth_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned SLOTS = BINS + 2;
  localparam int unsigned BW    = $clog2(SLOTS);
  localparam int unsigned CW    = $clog2(CHANNELS);
  localparam int unsigned DEPTH = 2 * CHANNELS * SLOTS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_BIN  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;
  localparam logic [2:0] ST_RRD  = 3'd5;
  localparam logic [2:0] ST_RDAT = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  in_beat_t beat;
  assign beat = in_beat_t'(s_axis_tdata[60:0]);

  logic signed [AMP_W-1:0] thr_m_q, thr_h_q, thr_l_q;
  logic signed [AMP_W-1:0] buf_a [CHANNELS];
  logic signed [AMP_W-1:0] buf_b [CHANNELS];
  logic signed [AMP_W-1:0] buf_t [CHANNELS];
  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rdata_q;

  logic [2:0]    st_q;
  logic [AW-1:0] clr_q;
  logic          bank_q, tb_q, rd_oob_q;
  logic [CW-1:0] ch_q;
  logic [AW-1:0] addr_q;
  logic          ovalid_q, okind_q, ota_q, otb_q;
  logic [OUT_CNT_W-1:0] ocnt_q;

  logic [BW-1:0] bin;
  logic signed [AMP_W-1:0] bin_x;
  assign bin_x = bank_q ? buf_b[ch_q] : buf_a[ch_q];

  cth_binner #(.BINS(BINS), .BW(BW)) u_binner (
    .clk_i(clk_i), .x_i(bin_x), .bin_o(bin)
  );

  // Trigger logic on the buffer, with the current beat forwarded.
  logic signed [AMP_W-1:0] t [CHANNELS];
  logic ta, tb;
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      t[i] = (beat.channel[CW-1:0] == CW'(i)) ? beat.trigger_sample : buf_t[i];
    end
    ta = ((t[2] > thr_h_q && t[3] > thr_m_q) || (t[6] > thr_m_q && t[7] > thr_l_q)) &&
         (t[10] > thr_h_q || t[14] > thr_h_q);
    tb = ((t[0] > thr_m_q && t[1] > thr_m_q) || (t[4] > thr_m_q && t[5] > thr_m_q)) &&
         ((t[8] > thr_m_q && t[9] > thr_m_q) || (t[12] > thr_m_q && t[13] > thr_m_q));
  end

  logic in_acc, out_acc;
  assign s_axis_tready = (st_q == ST_IDLE) && !ovalid_q;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Histogram address for bank, channel, bin.
  function automatic logic [AW-1:0] haddr(logic b, logic [CW-1:0] c, logic [BW-1:0] n);
    haddr = AW'(b) * AW'(CHANNELS * SLOTS) + AW'(c) * AW'(SLOTS) + AW'(n);
  endfunction

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [COUNT_WIDTH-1:0] mem_wd;
  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = (rdata_q == CMAX) ? rdata_q : rdata_q + 1'b1;
    if (st_q == ST_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = '0;
    end else if (st_q == ST_WR) begin
      mem_we = 1'b1;
    end
  end

  // Histogram memory: one write port, one registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[addr_q];
  end

  // Channel buffers.
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser == FUNC_SAMPLE) begin
      buf_a[beat.channel[CW-1:0]] <= beat.sample_a;
      buf_b[beat.channel[CW-1:0]] <= beat.sample_b;
      buf_t[beat.channel[CW-1:0]] <= beat.trigger_sample;
    end
  end

  // Thresholds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_m_q <= THR_MAIN_RST;
      thr_h_q <= THR_HIGH_RST;
      thr_l_q <= THR_LOW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAIN: thr_m_q <= cfg_data_i;
        REG_HIGH: thr_h_q <= cfg_data_i;
        REG_LOW:  thr_l_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer: clear, accept, walk fills, serve reads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_CLR;
      clr_q    <= '0;
      bank_q   <= 1'b0;
      ch_q     <= '0;
      tb_q     <= 1'b0;
      rd_oob_q <= 1'b0;
      addr_q   <= '0;
      ovalid_q <= 1'b0;
      okind_q  <= KIND_TRIG;
      ota_q    <= 1'b0;
      otb_q    <= 1'b0;
      ocnt_q   <= '0;
    end else begin
      if (out_acc) ovalid_q <= 1'b0;
      case (st_q)
        ST_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(DEPTH - 1)) st_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == FUNC_READ) begin
              bank_q   <= beat.read_bank;
              rd_oob_q <= 32'(beat.read_bin) >= SLOTS;
              addr_q   <= haddr(beat.read_bank, beat.channel[CW-1:0], BW'(beat.read_bin));
              st_q     <= ST_RRD;
            end else if (s_axis_tlast) begin
              tb_q <= tb;
              okind_q <= KIND_TRIG;
              ota_q <= ta;
              otb_q <= tb;
              ocnt_q <= '0;
              ch_q <= '0;
              bank_q <= !ta;
              if (ta || tb) st_q <= ST_BIN;
              else ovalid_q <= 1'b1;
            end
          end
        end
        ST_BIN: st_q <= ST_OUT;   // binner stage one
        ST_OUT: begin             // binner stage two done
          addr_q <= haddr(bank_q, ch_q, bin);
          st_q   <= ST_RD;
        end
        ST_RD: st_q <= ST_WR;
        ST_WR: begin
          if (ch_q == CW'(CHANNELS - 1)) begin
            ch_q <= '0;
            if (!bank_q && tb_q) begin
              bank_q <= 1'b1;
              st_q <= ST_BIN;
            end else begin
              ovalid_q <= 1'b1;
              st_q <= ST_IDLE;
            end
          end else begin
            ch_q <= ch_q + 1'b1;
            st_q <= ST_BIN;
          end
        end
        ST_RRD: st_q <= ST_RDAT;
        ST_RDAT: begin
          okind_q <= KIND_READ;
          ota_q <= 1'b0;
          otb_q <= 1'b0;
          if (rd_oob_q) ocnt_q <= '0;
          else if (COUNT_WIDTH > OUT_CNT_W && (rdata_q >> OUT_CNT_W) != '0) ocnt_q <= '1;
          else ocnt_q <= OUT_CNT_W'(rdata_q);
          ovalid_q <= 1'b1;
          st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tdata  = {6'b0, ocnt_q, otb_q, ota_q};

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, in_acc |-> st_q == ST_IDLE && !ovalid_q,
               "beat accepted while busy")
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, (ovalid_q && !m_axis_tready) |=> ovalid_q,
               "result dropped while stalled")
  `ASSERT_IMPL(a_trig_cnt0, clk_i, rst_ni, (ovalid_q && okind_q == KIND_TRIG) |-> ocnt_q == '0,
               "trigger report with count")
endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import cth_pkg::*;

  typedef struct {
    logic        func;
    logic [3:0]  chan;
    logic [15:0] amp_a;
    logic [15:0] amp_b;
    logic [15:0] amp_t;
    logic        last;
    logic        bank;
    logic [7:0]  bin;
  } beat_t;

  typedef struct {
    logic        kind;
    logic        trig_a;
    logic        trig_b;
    logic [31:0] count;
  } result_t;

  localparam int NCH   = 16;
  localparam int NSLOT = 202;
  localparam int LIMIT = 1000000;
  localparam int SETTLE = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  coincidence_triggered_histogrammer_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  beat_t   pend_q[$];
  result_t hist_result_q[$];
  beat_t   cur_beat;

  // Shadow copy of thresholds, channel buffers and histogram store
  logic signed [15:0] thr_main, thr_high, thr_low;
  logic signed [15:0] buf_a[NCH], buf_b[NCH], buf_t[NCH];
  int unsigned        hist_cnt[2][NCH][NSLOT];

  int  send_idle, recv_idle;
  int  errors;
  int  cycles;
  int  rx_stall;
  bit  rx_hold_req;
  bit  rx_hold_done;
  int  pushed;

  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  function automatic int bin_index(logic signed [15:0] x);
    int off;
    off = int'(x) + 200;
    if (off < 0) return 0;
    if (off >= 750) return NSLOT - 1;
    return (off * 200) / 750 + 1;
  endfunction

  function automatic void bump(int bank, int ch, logic signed [15:0] x);
    int b;
    b = bin_index(x);
    if (hist_cnt[bank][ch][b] != 32'hFFFF_FFFF) hist_cnt[bank][ch][b]++;
  endfunction

  // Work out the result of one accepted beat and update the shadow state
  task automatic predict_beat(beat_t bt);
    result_t r;
    bit      ta, tb;
    r.kind = KIND_READ; r.trig_a = 1'b0; r.trig_b = 1'b0; r.count = '0;
    if (bt.func == FUNC_READ) begin
      if (bt.bin < NSLOT) r.count = hist_cnt[bt.bank][bt.chan][bt.bin];
      hist_result_q.push_back(r);
    end else begin
      buf_a[bt.chan] = bt.amp_a;
      buf_b[bt.chan] = bt.amp_b;
      buf_t[bt.chan] = bt.amp_t;
      if (bt.last) begin
        ta = ((buf_t[2] > thr_high && buf_t[3] > thr_main) ||
              (buf_t[6] > thr_main && buf_t[7] > thr_low)) &&
             (buf_t[10] > thr_high || buf_t[14] > thr_high);
        tb = ((buf_t[0] > thr_main && buf_t[1] > thr_main) ||
              (buf_t[4] > thr_main && buf_t[5] > thr_main)) &&
             ((buf_t[8] > thr_main && buf_t[9] > thr_main) ||
              (buf_t[12] > thr_main && buf_t[13] > thr_main));
        for (int i = 0; i < NCH; i++) begin
          if (ta) bump(0, i, buf_a[i]);
          if (tb) bump(1, i, buf_b[i]);
        end
        r.kind = KIND_TRIG; r.trig_a = ta; r.trig_b = tb;
        hist_result_q.push_back(r);
      end
    end
  endtask

  // Driver: advance to the next pending beat when the slot is free
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_beat(cur_beat);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur_beat = pend_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {3'b000, cur_beat.bin, cur_beat.bank, cur_beat.amp_t,
                            cur_beat.amp_b, cur_beat.amp_a, cur_beat.chan};
          s_axis_tuser  <= cur_beat.func;
          s_axis_tlast  <= cur_beat.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down in cycles
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_stall     <= 0;
      rx_hold_done <= 1'b0;
    end else if (rx_hold_req && !rx_hold_done) begin
      rx_stall     <= 400;
      rx_hold_done <= 1'b1;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
    end
  end

  // Monitor: check each result beat against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    result_t e;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hist_result_q.size() == 0) begin
          $display("%0t: unexpected result beat kind=%0b data=%h", $realtime,
                   m_axis_tuser, m_axis_tdata);
          errors++;
        end else begin
          e = hist_result_q.pop_front();
          if (m_axis_tuser !== e.kind) begin
            $display("%0t: kind expected %0b actual %0b", $realtime, e.kind, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[0] !== e.trig_a) begin
            $display("%0t: trigger_a expected %0b actual %0b", $realtime, e.trig_a,
                     m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tdata[1] !== e.trig_b) begin
            $display("%0t: trigger_b expected %0b actual %0b", $realtime, e.trig_b,
                     m_axis_tdata[1]);
            errors++;
          end
          if (m_axis_tdata[33:2] !== e.count) begin
            $display("%0t: bin_count expected %0d actual %0d", $realtime, e.count,
                     m_axis_tdata[33:2]);
            errors++;
          end
        end
      end
      if (rx_stall > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Abort on a stuck run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] rand_amp();
    if ($urandom_range(99) < 85) return 16'($signed($urandom_range(1100)) - 350);
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_trig();
    if ($urandom_range(99) < 90) return 16'($signed($urandom_range(600)) - 150);
    return 16'($urandom);
  endfunction

  task automatic add_beat(logic func, logic [3:0] ch, logic [15:0] a, logic [15:0] b,
                          logic [15:0] t, logic last, logic bank, logic [7:0] bin);
    beat_t bt;
    bt.func = func; bt.chan = ch; bt.amp_a = a; bt.amp_b = b; bt.amp_t = t;
    bt.last = last; bt.bank = bank; bt.bin = bin;
    pend_q.push_back(bt);
    pushed++;
  endtask

  task automatic add_read(logic [3:0] ch, logic bank, logic [7:0] bin);
    add_beat(FUNC_READ, ch, 16'($urandom), 16'($urandom), 16'($urandom),
             1'($urandom), bank, bin);
  endtask

  // One event: all channels in shuffled order when full, else n random ones
  task automatic add_event(int n, bit full);
    int order[NCH];
    int j, tmp;
    for (int i = 0; i < NCH; i++) order[i] = i;
    for (int i = NCH - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i]; order[i] = order[j]; order[j] = tmp;
    end
    if (full) n = NCH;
    for (int i = 0; i < n; i++)
      add_beat(FUNC_SAMPLE, full ? 4'(order[i]) : 4'($urandom), rand_amp(), rand_amp(),
               rand_trig(), i == n - 1, 1'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || s_axis_tvalid || hist_result_q.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_MAIN: thr_main = val;
      REG_HIGH: thr_high = val;
      default:  thr_low  = val;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_thresholds(logic [15:0] m, logic [15:0] h, logic [15:0] l);
    write_reg(REG_MAIN, m);
    write_reg(REG_HIGH, h);
    write_reg(REG_LOW, l);
  endtask

  task automatic random_items(int target);
    int r;
    target += pushed;
    while (pushed < target) begin
      r = $urandom_range(99);
      if (r < 60) add_event($urandom_range(1, NCH), $urandom_range(3) == 0);
      else if (r < 88)
        add_read(4'($urandom), 1'($urandom),
                 $urandom_range(9) == 0 ? 8'($urandom) : 8'($urandom_range(201)));
      else
        add_beat(FUNC_SAMPLE, 4'($urandom), rand_amp(), rand_amp(), rand_trig(), 1'b0,
                 1'($urandom), 8'($urandom));
    end
  endtask

  task automatic all_trig(logic [15:0] t);
    for (int i = 0; i < NCH; i++)
      add_beat(FUNC_SAMPLE, 4'(i), 16'($urandom), 16'($urandom), t, i == NCH - 1,
               1'b0, 8'd0);
  endtask

  initial begin
    errors = 0; cycles = 0; pushed = 0;
    rx_hold_req = 1'b0;
    send_idle = 21; recv_idle = 68;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    thr_main = THR_MAIN_RST; thr_high = THR_HIGH_RST; thr_low = THR_LOW_RST;
    for (int i = 0; i < NCH; i++) begin
      buf_a[i] = '0; buf_b[i] = '0; buf_t[i] = '0;
    end
    foreach (hist_cnt[k, c, s]) hist_cnt[k][c][s] = 0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: bin edges, extreme amplitudes, first event covers every channel
    set_thresholds(16'sd150, 16'sd200, 16'sd100);
    for (int i = 0; i < NCH; i++) begin
      logic [15:0] a;
      case (i)
        0: a = 16'h8000;  1: a = 16'h7FFF;  2: a = -16'sd200;  3: a = -16'sd201;
        4: a = 16'sd549;  5: a = 16'sd550;  6: a = 16'sd0;     default: a = rand_amp();
      endcase
      add_beat(FUNC_SAMPLE, 4'(i), a, a, 16'h7FFF, i == NCH - 1, 1'b1, 8'hFF);
    end
    add_read(4'd0, 1'b0, 8'd0);
    add_read(4'd1, 1'b1, 8'd201);
    add_read(4'd2, 1'b0, 8'd1);
    add_read(4'd4, 1'b1, 8'd200);
    add_read(4'd15, 1'b0, 8'd202);
    add_read(4'd3, 1'b1, 8'd255);
    // Event of one channel only keeps the rest from before
    add_beat(FUNC_SAMPLE, 4'd9, 16'h8000, 16'h7FFF, 16'h8000, 1'b1, 1'b0, 8'd0);
    drain();

    // Extreme thresholds: everything above the floor, then nothing above the top
    set_thresholds(16'h8000, 16'h8000, 16'h8000);
    all_trig(16'h8001);
    all_trig(16'h8000);
    drain();
    set_thresholds(16'h7FFF, 16'h7FFF, 16'h7FFF);
    all_trig(16'h7FFF);
    add_read(4'd7, 1'b0, 8'd0);
    drain();

    // Random, sender idles little and receiver often
    set_thresholds(16'($urandom_range(250, 50)), 16'($urandom_range(300, 100)),
                   16'($urandom_range(200, 0)));
    random_items(60);
    while (pend_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    // Pause the sender until every result is back
    while (hist_result_q.size() > 0) @(posedge clk_i);
    random_items(60);
    drain();

    // Random, the other way round
    send_idle = 68; recv_idle = 21;
    set_thresholds(16'($urandom_range(250, 50)), 16'($urandom_range(300, 100)),
                   16'($urandom_range(200, 0)));
    random_items(150);
    drain();

    // Random, no idling; receiver holds off long at the start
    send_idle = 0; recv_idle = 0;
    set_thresholds(16'sd150, 16'sd200, 16'sd100);
    rx_hold_req = 1'b1;
    random_items(150);
    drain();

    if (errors == 0 && hist_result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
